// ----- design/sensor_liveness_watchdog_macros.svh -----
// assertion macros for the sensor liveness watchdog
`ifndef SENSOR_LIVENESS_WATCHDOG_MACROS_SVH
`define SENSOR_LIVENESS_WATCHDOG_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SLW_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sensor liveness watchdog: assertion failed");

// next-cycle implication, disabled while in reset
`define SLW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sensor liveness watchdog: assertion failed");

`endif

// ----- design/slw_pkg.sv -----
// shared types and constants of the sensor liveness watchdog
`timescale 1ns / 1ps

package slw_pkg;

    localparam int ENTRIES_DEF    = 10;
    localparam int TIME_WIDTH_DEF = 32;

    localparam int KEY_W     = 64;
    localparam int CFG_TIME_W = 31;
    localparam int TRIES_W   = 4;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [CFG_TIME_W-1:0] TIMEOUT_RST  = 31'd8000;
    localparam logic [CFG_TIME_W-1:0] INTERVAL_RST = 31'd30000;
    localparam logic [TRIES_W-1:0]    TRIES_RST    = 4'd3;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ALIVE  = 3'd1,
        OP_LOST   = 3'd2,
        OP_BEGIN  = 3'd3,
        OP_KEEP   = 3'd4,
        OP_END    = 3'd5,
        OP_QUERY  = 3'd6
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_DONE    = 3'd0,
        ACT_RECOVER = 3'd1,
        ACT_NUDGE   = 3'd2,
        ACT_DEAD    = 3'd3,
        ACT_REVIVED = 3'd4,
        ACT_DROPPED = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MODE_ONLINE  = 2'd0,
        MODE_RECOVER = 2'd1,
        MODE_DEAD    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_TIMEOUT  = 2'd0,
        REG_INTERVAL = 2'd1,
        REG_TRIES    = 2'd2
    } reg_idx_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic    eval;
        logic    apply;
        logic    shift;
        opcode_t op;
        logic    known;
        logic    any_match;
    } cell_ctl_t;

    // lookup carries, rippling from cell 0 upward
    typedef struct packed {
        logic free_seen;
        logic match_seen;
        logic dead_seen;
    } chain_t;

    // per-cell record, shifted toward cell 0 during the drain
    typedef struct packed {
        logic                ev;
        action_t             action;
        logic [KEY_W-1:0]    key;
        logic [TRIES_W-1:0]  attempt;
        logic                used;
        logic                online;
    } rec_t;

endpackage

// ----- design/slw_cell.sv -----
// one table entry of the watchdog with its lookup carries and drain stage
`timescale 1ns / 1ps

module slw_cell import slw_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_ctl_t             ctl,
    input  logic [KEY_W-1:0]      key_in,
    input  logic [TIME_WIDTH-1:0] now_in,
    input  logic [CFG_TIME_W-1:0] cfg_timeout,
    input  logic [CFG_TIME_W-1:0] cfg_interval,
    input  logic [TRIES_W-1:0]    cfg_tries,
    input  chain_t                chain_in,
    output chain_t                chain_out,
    input  rec_t                  rec_in,
    output rec_t                  rec_out
);

    localparam int CW = (TIME_WIDTH > CFG_TIME_W) ? TIME_WIDTH : CFG_TIME_W;

    logic                  used_reg, used_next;
    logic                  seen_reg, seen_next;
    mode_t                 mode_reg, mode_next;
    logic [TRIES_W-1:0]    tries_reg, tries_next;
    logic [TIME_WIDTH-1:0] due_reg, due_next;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    logic                  kept_reg, kept_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    rec_t                  rec_reg, rec_next;

    logic                  match_reg, free_reg, tmo_reg, rty_reg;
    logic                  match, first_free, tmo, rty, sel;
    logic [TIME_WIDTH-1:0] d_alive, d_due;

    assign match      = used_reg && (key_reg == key_in);
    assign first_free = !used_reg && !chain_in.free_seen;

    assign chain_out.free_seen  = chain_in.free_seen | !used_reg;
    assign chain_out.match_seen = chain_in.match_seen | match;
    assign chain_out.dead_seen  = chain_in.dead_seen | (match && mode_reg == MODE_DEAD);

    // wrap-safe differences: negative when the top bit is set
    assign d_alive = now_in - last_reg;
    assign d_due   = now_in - due_reg;
    assign tmo     = !d_alive[TIME_WIDTH-1] && (CW'(d_alive) > CW'(cfg_timeout));
    assign rty     = !d_due[TIME_WIDTH-1];

    assign sel = match_reg | (!ctl.any_match & free_reg);

    always_comb begin
        used_next  = used_reg;
        seen_next  = seen_reg;
        mode_next  = mode_reg;
        tries_next = tries_reg;
        due_next   = due_reg;
        last_next  = last_reg;
        kept_next  = kept_reg;
        key_next   = key_reg;
        rec_next.ev      = 1'b0;
        rec_next.action  = ACT_DONE;
        rec_next.attempt = '0;

        // a free slot claimed by alive, known lost or keep starts out fresh
        if (sel && !used_reg &&
            (ctl.op == OP_ALIVE || ctl.op == OP_KEEP || (ctl.op == OP_LOST && ctl.known))) begin
            used_next  = 1'b1;
            seen_next  = 1'b0;
            key_next   = key_in;
            mode_next  = MODE_ONLINE;
            tries_next = '0;
            due_next   = '0;
            last_next  = '0;
        end

        unique case (ctl.op)
            OP_ALIVE: begin
                if (sel) begin
                    seen_next = 1'b1;
                    last_next = now_in;
                    if (mode_next != MODE_ONLINE) begin
                        if (mode_next == MODE_DEAD) begin
                            rec_next.ev     = 1'b1;
                            rec_next.action = ACT_REVIVED;
                        end
                        mode_next  = MODE_ONLINE;
                        tries_next = '0;
                    end
                end
            end
            OP_LOST: begin
                if (sel && ctl.known && mode_next == MODE_ONLINE) begin
                    mode_next       = MODE_RECOVER;
                    tries_next      = cfg_tries;
                    due_next        = now_in;
                    rec_next.ev     = 1'b1;
                    rec_next.action = ACT_RECOVER;
                end
            end
            OP_KEEP: begin
                if (sel) begin
                    if (!seen_next) begin
                        seen_next = 1'b1;
                        last_next = now_in;
                    end
                    kept_next = 1'b1;
                end
            end
            OP_BEGIN: begin
                kept_next = 1'b0;
            end
            OP_END: begin
                if (used_reg && !kept_reg) begin
                    used_next       = 1'b0;
                    seen_next       = 1'b0;
                    rec_next.ev     = 1'b1;
                    rec_next.action = ACT_DROPPED;
                end
            end
            OP_TICK: begin
                if (used_reg) begin
                    if (mode_reg == MODE_ONLINE && seen_reg && tmo_reg) begin
                        mode_next       = MODE_RECOVER;
                        tries_next      = cfg_tries;
                        due_next        = now_in;
                        rec_next.ev     = 1'b1;
                        rec_next.action = ACT_RECOVER;
                    end else if (mode_reg == MODE_RECOVER && rty_reg) begin
                        rec_next.ev = 1'b1;
                        if (tries_reg != '0) begin
                            tries_next       = tries_reg - 1'b1;
                            due_next         = now_in + TIME_WIDTH'(cfg_interval);
                            rec_next.action  = ACT_NUDGE;
                            rec_next.attempt = cfg_tries - tries_next;
                        end else begin
                            mode_next       = MODE_DEAD;
                            rec_next.action = ACT_DEAD;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        rec_next.key    = key_next;
        rec_next.used   = used_next;
        rec_next.online = (mode_next == MODE_ONLINE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            mode_reg  <= MODE_ONLINE;
            tries_reg <= '0;
            due_reg   <= '0;
            last_reg  <= '0;
            kept_reg  <= 1'b0;
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
            tmo_reg   <= 1'b0;
            rty_reg   <= 1'b0;
        end else begin
            if (ctl.eval) begin
                match_reg <= match;
                free_reg  <= first_free;
                tmo_reg   <= tmo;
                rty_reg   <= rty;
            end
            if (ctl.apply) begin
                used_reg  <= used_next;
                seen_reg  <= seen_next;
                mode_reg  <= mode_next;
                tries_reg <= tries_next;
                due_reg   <= due_next;
                last_reg  <= last_next;
                kept_reg  <= kept_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.apply) begin
            key_reg <= key_next;
            rec_reg <= rec_next;
        end else if (ctl.shift) begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule

// ----- design/sensor_liveness_watchdog.sv -----
// top level of the sensor liveness watchdog: sequencer, cell chain, output and register port
//
//   channel   dir   group                                   one transfer
//   s_        in    s_tvalid s_tready s_tdata s_tuser      one request
//   m_        out   m_tvalid m_tready m_tdata m_tuser m_tlast  one result
//   apb       in    psel penable pwrite paddr pwdata prdata pready  one register
//
// a request is accepted only in the idle state, once the final result of the previous request is in the output register
// the drain moves one cell record per cycle down the chain, unless the output register holds it
// a full output register holds the drain at any cell that carries a result
// synchronous active-low reset clears the table to empty and loads the register defaults
`timescale 1ns / 1ps
`include "sensor_liveness_watchdog_macros.svh"

module sensor_liveness_watchdog import slw_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [103:0]      s_tdata,   // sensor_key, now_time, known_enabled
    input  logic [2:0]        s_tuser,   // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [87:0]       m_tdata,   // subject_key, attempt_number, is_offline,
                                         // tracked_count, online_count, missing_count
    output logic [2:0]        m_tuser,   // action
    output logic              m_tlast,   // last_result
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_APPLY = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_TIME_W-1:0] timeout_reg, interval_reg;
    logic [TRIES_W-1:0]    tries_reg;
    reg_idx_t              reg_idx;
    logic                  cfg_wr;

    opcode_t               op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  known_reg;
    logic                  any_match_reg, offline_reg;

    logic [CNT_W-1:0]      drain_cnt_reg, trk_cnt_reg, onl_cnt_reg;

    logic                  out_valid_reg;
    action_t               out_act_reg;
    logic [KEY_W-1:0]      out_key_reg;
    logic [TRIES_W-1:0]    out_att_reg;
    logic                  out_offl_reg, out_last_reg;
    logic [3:0]            out_trk_reg, out_onl_reg, out_mis_reg;

    cell_ctl_t             ctl;
    chain_t                chain_w [0:ENTRIES];
    rec_t                  rec_w   [0:ENTRIES];
    rec_t                  head;
    logic                  s_accept, out_free, shift, drain_last;
    logic [CNT_W-1:0]      mis_cnt;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_TIMEOUT:  prdata = {1'b0, timeout_reg};
            REG_INTERVAL: prdata = {1'b0, interval_reg};
            REG_TRIES:    prdata = {{(APB_DW - TRIES_W){1'b0}}, tries_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= TIMEOUT_RST;
            interval_reg <= INTERVAL_RST;
            tries_reg    <= TRIES_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TIMEOUT:  timeout_reg  <= pwdata[CFG_TIME_W-1:0];
                REG_INTERVAL: interval_reg <= pwdata[CFG_TIME_W-1:0];
                REG_TRIES:    tries_reg    <= pwdata[TRIES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign head       = rec_w[0];
    assign shift      = (state_reg == ST_DRAIN) && (!head.ev || out_free);
    assign drain_last = (drain_cnt_reg == CNT_W'(ENTRIES - 1));
    assign mis_cnt    = trk_cnt_reg - onl_cnt_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_APPLY;
            ST_APPLY: state_next = ST_DRAIN;
            ST_DRAIN: if (shift && drain_last) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            drain_cnt_reg <= '0;
            trk_cnt_reg   <= '0;
            onl_cnt_reg   <= '0;
            any_match_reg <= 1'b0;
            offline_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EVAL) begin
                any_match_reg <= chain_w[ENTRIES].match_seen;
                offline_reg   <= (op_reg == OP_QUERY) && chain_w[ENTRIES].dead_seen;
            end
            if (state_reg == ST_APPLY) begin
                drain_cnt_reg <= '0;
                trk_cnt_reg   <= '0;
                onl_cnt_reg   <= '0;
            end else if (shift) begin
                drain_cnt_reg <= drain_cnt_reg + 1'b1;
                trk_cnt_reg   <= trk_cnt_reg + CNT_W'(head.used);
                onl_cnt_reg   <= onl_cnt_reg + CNT_W'(head.used && head.online);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= opcode_t'(s_tuser[2:0]);
            key_reg   <= s_tdata[63:0];
            now_reg   <= TIME_WIDTH'(s_tdata[95:64]);
            known_reg <= s_tdata[96];
        end
    end

    // cell chain
    assign ctl.eval      = (state_reg == ST_EVAL);
    assign ctl.apply     = (state_reg == ST_APPLY);
    assign ctl.shift     = shift;
    assign ctl.op        = op_reg;
    assign ctl.known     = known_reg;
    assign ctl.any_match = any_match_reg;

    assign chain_w[0]     = '0;
    assign rec_w[ENTRIES] = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        slw_cell #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .key_in       (key_reg),
            .now_in       (now_reg),
            .cfg_timeout  (timeout_reg),
            .cfg_interval (interval_reg),
            .cfg_tries    (tries_reg),
            .chain_in     (chain_w[i]),
            .chain_out    (chain_w[i+1]),
            .rec_in       (rec_w[i+1]),
            .rec_out      (rec_w[i])
        );
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (shift && head.ev) begin
            out_valid_reg <= 1'b1;
        end else if (state_reg == ST_DONE && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift && head.ev) begin
            out_act_reg  <= head.action;
            out_key_reg  <= head.key;
            out_att_reg  <= head.attempt;
            out_offl_reg <= 1'b0;
            out_trk_reg  <= '0;
            out_onl_reg  <= '0;
            out_mis_reg  <= '0;
            out_last_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            out_act_reg  <= ACT_DONE;
            out_key_reg  <= key_reg;
            out_att_reg  <= '0;
            out_offl_reg <= offline_reg;
            out_trk_reg  <= 4'(trk_cnt_reg);
            out_onl_reg  <= 4'(onl_cnt_reg);
            out_mis_reg  <= 4'(mis_cnt);
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_mis_reg, out_onl_reg, out_trk_reg, out_offl_reg,
                       out_att_reg, out_key_reg};

    `SLW_ASSERT_IMPL(a_last_is_done, aclk, aresetn, m_tvalid, m_tlast == (m_tuser == ACT_DONE))
    `SLW_ASSERT_IMPL(a_counts_add_up, aclk, aresetn, m_tvalid && m_tlast, out_trk_reg == 4'(out_onl_reg + out_mis_reg))
    `SLW_ASSERT_IMPL(a_event_no_counts, aclk, aresetn, m_tvalid && !m_tlast, !out_offl_reg && out_trk_reg == 4'd0 && out_onl_reg == 4'd0)
    `SLW_ASSERT_NEXT(a_drain_bounded, aclk, aresetn, shift && drain_last, state_reg == ST_DONE)

endmodule
